// ===== hdl/ttg_pkg.sv =====
// Shared constants, types and helpers of the text terminal grid engine.
`default_nettype none
package ttg_pkg;

  localparam int ROWS   = 12;
  localparam int COLS   = 22;
  localparam int DEPTH  = ROWS * COLS;
  localparam int RIDX_W = $clog2(ROWS);
  localparam int CIDX_W = $clog2(COLS);
  localparam int ADDR_W = $clog2(DEPTH);

  // Fixed field widths of the item and result.
  localparam int OPC_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 5;

  localparam logic [OPC_W-1:0]  OP_PRINT = 2'd0;
  localparam logic [OPC_W-1:0]  OP_READ  = 2'd1;
  localparam logic [OPC_W-1:0]  OP_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SWEEP,
    ST_WR_CH,
    ST_WR_BLANK,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_BS,
    KIND_READ
  } kind_t;

  typedef struct packed {
    logic [COL_W-1:0]  read_col;
    logic [ROW_W-1:0]  read_row;
    logic [CHAR_W-1:0] char_code;
    logic [OPC_W-1:0]  opcode;
  } in_item_t;

  typedef struct packed {
    logic              scrolled;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic [CHAR_W-1:0] cell_value;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] wdata;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [RIDX_W-1:0] prow,
                                                  input logic [CIDX_W-1:0] col);
    logic [ADDR_W-1:0] base_addr;
    base_addr = ADDR_W'(prow) * ADDR_W'(COLS);
    return ADDR_W'(base_addr + ADDR_W'(col));
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ttg_grid_ram.sv =====
// Single-port character grid memory with registered read data.
`default_nettype none
module ttg_grid_ram
  import ttg_pkg::*;
(
  input  wire logic              clk,
  input  wire mem_req_t          req,
  output logic [CHAR_W-1:0]      rdata
);

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule
`default_nettype wire

// ===== hdl/ttg_seq.sv =====
// Item sequencer: cursor, row rotation, row valid bits and grid accesses.
`default_nettype none
module ttg_seq
  import ttg_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire in_item_t     in_item,
  output mem_req_t          mem_req,
  input  wire logic [CHAR_W-1:0] mem_rdata,
  input  wire logic         out_free,
  output logic              res_push,
  output result_t           res
);

  state_t state, state_next;
  kind_t  kind;

  logic [CIDX_W-1:0] col;
  logic [RIDX_W-1:0] row;
  logic [RIDX_W-1:0] base;
  logic [ROWS-1:0]   row_valid;
  logic [RIDX_W-1:0] tgt_row;
  logic [CIDX_W-1:0] tgt_col;
  logic [CIDX_W-1:0] blank_col;
  logic [RIDX_W-1:0] phys;
  logic [CIDX_W-1:0] cnt;
  logic [CHAR_W-1:0] ch;
  logic [CHAR_W-1:0] cell_byte;
  logic              scrolled;

  logic [RIDX_W:0]   row_sum;
  logic [RIDX_W-1:0] phys_now;
  logic              at_last_row;
  logic [RIDX_W-1:0] base_inc;
  logic              in_range;

  // Logical rows are rotated by base, so a scroll moves base instead of the row data.
  assign row_sum  = {1'b0, tgt_row} + {1'b0, base};
  assign phys_now = (row_sum >= (RIDX_W+1)'(ROWS)) ?
                    RIDX_W'(row_sum - (RIDX_W+1)'(ROWS)) : RIDX_W'(row_sum);

  assign at_last_row = (row == RIDX_W'(ROWS - 1));
  assign base_inc    = (base == RIDX_W'(ROWS - 1)) ? '0 : RIDX_W'(base + 1'b1);
  assign in_range    = (int'(in_item.read_row) < ROWS) && (int'(in_item.read_col) < COLS);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_item.opcode)
            OP_PRINT: begin
              if (in_item.char_code == CH_NEWLINE) begin
                state_next = ST_DONE;
              end else if (in_item.char_code == CH_BACKSPACE) begin
                state_next = (col != '0) ? ST_PREP : ST_DONE;
              end else begin
                state_next = ST_PREP;
              end
            end
            OP_READ: state_next = in_range ? ST_PREP : ST_DONE;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_PREP: begin
        if (kind == KIND_READ) begin
          state_next = row_valid[phys_now] ? ST_RD_WAIT : ST_DONE;
        end else if (!row_valid[phys_now]) begin
          // A blanked row needs zeros in memory only before a byte lands in it.
          state_next = (kind == KIND_CHAR) ? ST_SWEEP : ST_DONE;
        end else begin
          state_next = (kind == KIND_CHAR) ? ST_WR_CH : ST_WR_BLANK;
        end
      end
      ST_SWEEP:    state_next = (cnt == CIDX_W'(COLS - 1)) ? ST_WR_CH : ST_SWEEP;
      ST_WR_CH:    state_next = ST_WR_BLANK;
      ST_WR_BLANK: state_next = ST_DONE;
      ST_RD_WAIT:  state_next = ST_DONE;
      ST_DONE:     state_next = out_free ? ST_IDLE : ST_DONE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == ST_IDLE);
    res_push      = (state == ST_DONE) && out_free;
    mem_req.we    = 1'b0;
    mem_req.addr  = cell_addr(phys, tgt_col);
    mem_req.wdata = '0;
    case (state)
      ST_PREP: begin
        mem_req.addr = cell_addr(phys_now, tgt_col);
      end
      ST_SWEEP: begin
        mem_req.we   = 1'b1;
        mem_req.addr = cell_addr(phys, cnt);
      end
      ST_WR_CH: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = cell_addr(phys, tgt_col);
        mem_req.wdata = ch;
      end
      ST_WR_BLANK: begin
        mem_req.we   = 1'b1;
        mem_req.addr = cell_addr(phys, blank_col);
      end
      default: begin
      end
    endcase
    res.cell_value    = cell_byte;
    res.cursor_column = COL_W'(col);
    res.cursor_row    = ROW_W'(row);
    res.scrolled      = scrolled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      col       <= '0;
      row       <= '0;
      base      <= '0;
      row_valid <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            scrolled  <= 1'b0;
            cell_byte <= '0;
            ch        <= in_item.char_code;
            case (in_item.opcode)
              OP_PRINT: begin
                if (in_item.char_code == CH_NEWLINE) begin
                  col <= '0;
                  if (at_last_row) begin
                    row_valid[base] <= 1'b0;
                    base            <= base_inc;
                    scrolled        <= 1'b1;
                  end else begin
                    row <= RIDX_W'(row + 1'b1);
                  end
                end else if (in_item.char_code == CH_BACKSPACE) begin
                  kind      <= KIND_BS;
                  tgt_row   <= row;
                  if (col != '0) begin
                    col       <= CIDX_W'(col - 1'b1);
                    blank_col <= CIDX_W'(col - 1'b1);
                  end
                end else begin
                  kind <= KIND_CHAR;
                  if (col >= CIDX_W'(COLS - 1)) begin
                    tgt_col   <= '0;
                    blank_col <= CIDX_W'(1);
                    col       <= CIDX_W'(1);
                    if (at_last_row) begin
                      // The old top row becomes the new, blank bottom row.
                      row_valid[base] <= 1'b0;
                      base            <= base_inc;
                      scrolled        <= 1'b1;
                      tgt_row         <= row;
                    end else begin
                      row     <= RIDX_W'(row + 1'b1);
                      tgt_row <= RIDX_W'(row + 1'b1);
                    end
                  end else begin
                    tgt_col   <= col;
                    blank_col <= CIDX_W'(col + 1'b1);
                    col       <= CIDX_W'(col + 1'b1);
                    tgt_row   <= row;
                  end
                end
              end
              OP_READ: begin
                kind    <= KIND_READ;
                tgt_row <= RIDX_W'(in_item.read_row);
                tgt_col <= CIDX_W'(in_item.read_col);
              end
              OP_CLEAR: begin
                row_valid <= '0;
                base      <= '0;
                col       <= '0;
                row       <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_PREP: begin
          phys <= phys_now;
          cnt  <= '0;
        end
        ST_SWEEP: begin
          cnt <= CIDX_W'(cnt + 1'b1);
          if (cnt == CIDX_W'(COLS - 1)) begin
            row_valid[phys] <= 1'b1;
          end
        end
        ST_RD_WAIT: begin
          cell_byte <= mem_rdata;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ttg_out_stage.sv =====
// Output register that holds one result item until the receiver takes it.
`default_nettype none
module ttg_out_stage
  import ttg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire result_t  res,
  output logic          free,
  output logic          tvalid,
  input  wire logic     tready,
  output result_t       tdata
);

  assign free = !tvalid || tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (push) begin
      tvalid <= 1'b1;
    end else if (tready) begin
      tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      tdata <= res;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/text_terminal_grid_engine.sv =====
// Text terminal grid engine: a rows-by-columns byte grid with cursor and scrolling.
//
// Input items arrive on s_axis; each carries an opcode (print a byte, read a
// cell, clear the grid). Every item yields exactly one result item on m_axis
// with the read byte, the cursor after the item and a scroll flag.
// The grid lives in one single-port memory with registered read data.
// Rows are addressed through a rotating base, so a scroll moves the base and
// drops the valid bit of the row that becomes the bottom row; a clear drops
// all row valid bits. An invalid row reads as zeros.
// Newline, clear, backspace at column 0, out-of-range reads and unused opcodes go
// straight to the result; other items first pass the prepare state, where the
// physical row is looked up. A cell read from a live row waits for the memory;
// a backspace blanks a cell of a live row; a printed byte writes the byte, blanks
// the next cell and, into a blank row, first zeroes that row, one memory write per
// cycle. The next item is accepted in the cycle after the result is loaded.
// Synchronous reset empties the grid and homes the cursor.
// When the receiver stalls, the finished result waits in the output register
// while the next item is accepted and worked on; that item then waits until
// the output register is free.
`default_nettype none
module text_terminal_grid_engine
  import ttg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode[1:0], char_code[9:2], read_row[13:10], read_col[18:14], zeros above
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // cell_value[7:0], cursor_column[12:8], cursor_row[16:13], scrolled[17], zeros above
  output logic [23:0]      m_axis_tdata
);

  in_item_t          in_item;
  mem_req_t          mem_req;
  logic [CHAR_W-1:0] mem_rdata;
  logic              out_free;
  logic              res_push;
  result_t           res;
  result_t           out_data;

  assign in_item = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);

  ttg_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .out_free  (out_free),
    .res_push  (res_push),
    .res       (res)
  );

  ttg_grid_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  ttg_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .push   (res_push),
    .res    (res),
    .free   (out_free),
    .tvalid (m_axis_tvalid),
    .tready (m_axis_tready),
    .tdata  (out_data)
  );

  assign m_axis_tdata = {(24 - $bits(result_t))'(0), out_data};

endmodule
`default_nettype wire

// ===== hdl/ttg_checker.sv =====
// Port-level checks of the text terminal grid engine, bound to the top level.
`default_nettype none
module ttg_checker
  import ttg_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  // The result item must hold while it waits.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // The cursor never leaves the grid.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (int'(m_axis_tdata[12:8]) < COLS) &&
                      (int'(m_axis_tdata[16:13]) < ROWS))
    else $error("cursor outside the grid");

  // A scroll leaves the cursor at column 0 or 1 of the last row.
  a_scroll_pos: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[17] |->
      (int'(m_axis_tdata[16:13]) == ROWS - 1) &&
      (m_axis_tdata[12:8] == 5'd0 || m_axis_tdata[12:8] == 5'd1))
    else $error("scroll with cursor off the last row start");

  // An accepted item is never answered in the cycle right after it.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

endmodule

bind text_terminal_grid_engine ttg_checker u_ttg_checker (.*);
`default_nettype wire

// ===== verif/tb_text_terminal_grid_engine.sv =====
// Self-checking testbench for the text terminal grid engine: shadow grid, random traffic.
`timescale 1ns / 1ps
module tb_text_terminal_grid_engine;
  import ttg_pkg::*;

  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = COLS + 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  text_terminal_grid_engine dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow copy of the terminal contents and cursor.
  logic [CHAR_W-1:0] shadow_cells [ROWS][COLS];
  int                cur_col;
  int                cur_row;

  result_t pending_results [$];
  int      mismatch_count;
  int      burst_left;
  int      stall_mode;
  int      stall_phase_left;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("text_terminal_grid_engine: mismatch");
    $finish;
  end

  // Receiver: changes its stall behavior at the end of each phase of random length.
  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_phase_left = $urandom_range(40, 200);
    end
    stall_phase_left = stall_phase_left - 1;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (stall_phase_left % 4 == 0);
      default: m_axis_tready <= ((stall_phase_left / 12) % 2 == 0);
    endcase
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    got = m_axis_tdata[17:0];
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result with nothing pending, data %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.cell_value !== want.cell_value || got.cursor_column !== want.cursor_column ||
            got.cursor_row !== want.cursor_row || got.scrolled !== want.scrolled ||
            m_axis_tdata[23:18] !== 6'd0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: expected cell %h col %0d row %0d scr %0d, got cell %h col %0d row %0d scr %0d pad %h",
                     want.cell_value, want.cursor_column, want.cursor_row, want.scrolled,
                     got.cell_value, got.cursor_column, got.cursor_row, got.scrolled,
                     m_axis_tdata[23:18]);
        end
      end
    end
  end

  function automatic void clear_shadow();
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++)
        shadow_cells[r][c] = '0;
    cur_col = 0;
    cur_row = 0;
  endfunction

  // Moves the cursor to the next line; returns 1 when the grid scrolled up.
  function automatic bit line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row < ROWS)
      return 1'b0;
    for (int r = 0; r < ROWS - 1; r++)
      for (int c = 0; c < COLS; c++)
        shadow_cells[r][c] = shadow_cells[r+1][c];
    for (int c = 0; c < COLS; c++)
      shadow_cells[ROWS-1][c] = '0;
    cur_row = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic result_t terminal_update(input in_item_t it);
    result_t res;
    res = '0;
    case (it.opcode)
      OP_PRINT: begin
        if (it.char_code == CH_NEWLINE) begin
          res.scrolled = line_feed();
        end else if (it.char_code == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            shadow_cells[cur_row][cur_col] = '0;
          end
        end else begin
          if (cur_col >= COLS - 1)
            res.scrolled = line_feed();
          shadow_cells[cur_row][cur_col] = it.char_code;
          cur_col++;
          shadow_cells[cur_row][cur_col] = '0;
        end
      end
      OP_READ: begin
        if (it.read_row < ROWS && it.read_col < COLS)
          res.cell_value = shadow_cells[it.read_row][it.read_col];
      end
      OP_CLEAR: clear_shadow();
      default: ;
    endcase
    res.cursor_column = COL_W'(cur_col);
    res.cursor_row = ROW_W'(cur_row);
    return res;
  endfunction

  // Called at a falling edge; returns at a falling edge with no pending assignment to valid.
  task automatic send_item(input in_item_t it);
    s_axis_tdata <= {5'd0, it};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(terminal_update(it));
    @(negedge clk);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic in_item_t random_fields();
    in_item_t it;
    it.opcode = OPC_W'($urandom_range(0, 3));
    it.char_code = CHAR_W'($urandom_range(0, 255));
    it.read_row = ROW_W'($urandom_range(0, 15));
    it.read_col = COL_W'($urandom_range(0, 31));
    return it;
  endfunction

  function automatic in_item_t print_of(input logic [CHAR_W-1:0] ch);
    in_item_t it;
    it = random_fields();
    it.opcode = OP_PRINT;
    it.char_code = ch;
    return it;
  endfunction

  function automatic logic [CHAR_W-1:0] stored_byte();
    logic [CHAR_W-1:0] ch;
    ch = CHAR_W'($urandom_range(0, 255));
    if (ch == CH_NEWLINE || ch == CH_BACKSPACE)
      ch = CHAR_W'($urandom_range(32, 126));
    return ch;
  endfunction

  // Reads mostly cells near the cursor, where the text lives.
  function automatic in_item_t nearby_read();
    in_item_t it;
    it = random_fields();
    it.opcode = OP_READ;
    if ($urandom_range(0, 3) != 0) begin
      it.read_row = ROW_W'(cur_row - $urandom_range(0, cur_row > 2 ? 2 : cur_row));
      it.read_col = COL_W'($urandom_range(0, COLS - 1));
    end
    return it;
  endfunction

  function automatic in_item_t read_at(input int r, input int c);
    in_item_t it;
    it = random_fields();
    it.opcode = OP_READ;
    it.read_row = ROW_W'(r);
    it.read_col = COL_W'(c);
    return it;
  endfunction

  task automatic test_directed();
    in_item_t it;
    send_item(read_at(0, 0));
    send_item(print_of(8'hFF));
    send_item(print_of(8'h00));
    send_item(print_of(8'h41));
    send_item(print_of(CH_BACKSPACE));
    send_item(read_at(0, 0));
    send_item(read_at(0, 1));
    send_item(read_at(0, 2));
    send_item(read_at(15, 31));
    send_item(read_at(ROWS, 0));
    send_item(read_at(0, COLS));
    send_item(read_at(ROWS - 1, COLS - 1));
    send_item(print_of(CH_NEWLINE));
    send_item(print_of(CH_BACKSPACE));
    it = '1;
    it.opcode = OP_UNUSED;
    send_item(it);
    it = '0;
    it.opcode = OP_UNUSED;
    send_item(it);
    it = '1;
    it.opcode = OP_CLEAR;
    send_item(it);
    send_item(read_at(0, 0));
    it = '0;
    it.opcode = OP_READ;
    it.read_row = '1;
    send_item(it);
    send_item(print_of(8'h7E));
  endtask

  // Lines of text ended by newlines; long lines wrap and many lines scroll.
  task automatic test_text_lines(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(COLS - 2, 2 * COLS + 3)
                                        : $urandom_range(0, COLS - 1);
      for (int i = 0; i < len; i++) begin
        send_item(print_of(stored_byte()));
        sent++;
        if ($urandom_range(0, 5) == 0) begin
          send_item(nearby_read());
          sent++;
        end
      end
      if ($urandom_range(0, 4) != 0) begin
        send_item(print_of(CH_NEWLINE));
        sent++;
      end
    end
  endtask

  // Typing with runs of backspaces, some longer than the line.
  task automatic test_editing(input int n_items);
    int sent;
    int run;
    sent = 0;
    while (sent < n_items) begin
      run = $urandom_range(1, COLS + 4);
      for (int i = 0; i < run; i++) begin
        send_item(print_of(stored_byte()));
        sent++;
      end
      run = $urandom_range(1, COLS + 2);
      for (int i = 0; i < run; i++) begin
        send_item(print_of(CH_BACKSPACE));
        sent++;
      end
      for (int i = 0; i < 3; i++) begin
        send_item(nearby_read());
        sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_item(print_of(CH_NEWLINE));
        sent++;
      end
    end
  endtask

  task automatic test_random_noise(input int n_items);
    in_item_t it;
    for (int i = 0; i < n_items; i++) begin
      it = random_fields();
      // Keep clears rare so the grid fills up between them.
      if (it.opcode == OP_CLEAR && $urandom_range(0, 15) != 0)
        it.opcode = OP_PRINT;
      send_item(it);
    end
  endtask

  // Screens of text, each ended by a clear; the sender drains before some clears.
  task automatic test_clear_screens(input int n_screens);
    in_item_t it;
    for (int s = 0; s < n_screens; s++) begin
      test_text_lines($urandom_range(20, 60));
      send_item(read_at(cur_row, 0));
      if (s % 2 == 0)
        wait_all_results();
      it = random_fields();
      it.opcode = OP_CLEAR;
      send_item(it);
      send_item(read_at($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1)));
    end
  endtask

  initial begin
    clear_shadow();
    mismatch_count = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_phase_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_text_lines(800);
    wait_all_results();
    test_editing(350);
    test_random_noise(300);
    test_clear_screens(6);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("text_terminal_grid_engine: match");
    end else begin
      $display("text_terminal_grid_engine: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ttg_pkg.sv
hdl/ttg_grid_ram.sv
hdl/ttg_seq.sv
hdl/ttg_out_stage.sv
hdl/text_terminal_grid_engine.sv
hdl/ttg_checker.sv
verif/tb_text_terminal_grid_engine.sv
